FILE: design/multiturn_encoder_velocity_tracker_unit_assert.svh
// Assertion macros used by the checker file of the tracker.
`ifndef MULTITURN_ENCODER_VELOCITY_TRACKER_UNIT_ASSERT_SVH
`define MULTITURN_ENCODER_VELOCITY_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define METVT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define METVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/metvt_pkg.sv
// Package: widths, constants, codes and control structs of the tracker.
package metvt_pkg;

  localparam int ANGLE_BITS_DEF    = 14;
  localparam int ROTATION_BITS_DEF = 24;

  localparam int THR_W      = 14;
  localparam int FB_W       = 16;
  localparam int TS_W       = 32;
  localparam int BYTE_W     = 8;
  localparam int RAW_ANG_W  = 14;
  localparam int VEL_W      = 32;

  localparam logic [THR_W-1:0] WRAP_THR_RESET = 14'd13107;
  localparam logic [FB_W-1:0]  FB_RESET       = 16'd1000;

  // counts per second scale
  localparam int               VEL_SCALE_W = 20;
  localparam logic [VEL_SCALE_W-1:0] VEL_SCALE = 20'd1000000;

  localparam int CHUNK_W   = 16;
  localparam int DIV_STEPS = VEL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_US    = 2'd1;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_VELOCITY = 1'b1;

  typedef struct packed {
    logic load_sample;
    logic load_velocity;
    logic mul_step;
    logic div_check;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ovf;
  } status_t;

endpackage

FILE: design/metvt_in_if.sv
// Input channel: one sample or velocity-read word.
interface metvt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [metvt_pkg::BYTE_W-1:0]      angle_high_byte;
  logic [metvt_pkg::BYTE_W-1:0]      angle_low_byte;
  logic [metvt_pkg::TS_W-1:0]        timestamp_us;

  modport source (output valid, operation, angle_high_byte, angle_low_byte, timestamp_us,
                  input ready);
  modport sink   (input valid, operation, angle_high_byte, angle_low_byte, timestamp_us,
                  output ready);
endinterface

FILE: design/metvt_out_if.sv
// Output channel: one tracker result word.
interface metvt_out_if #(
  parameter int ANGLE_BITS    = metvt_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_BITS = metvt_pkg::ROTATION_BITS_DEF
);
  logic                                           valid;
  logic                                           ready;
  logic        [ANGLE_BITS-1:0]                   angle_counts;
  logic signed [ROTATION_BITS-1:0]                rotation_count;
  logic signed [ANGLE_BITS+ROTATION_BITS:0]       position_counts;
  logic signed [metvt_pkg::VEL_W-1:0]             velocity_counts_per_s;
  logic                                           velocity_valid;

  modport source (output valid, angle_counts, rotation_count, position_counts,
                  velocity_counts_per_s, velocity_valid, input ready);
  modport sink   (input valid, angle_counts, rotation_count, position_counts,
                  velocity_counts_per_s, velocity_valid, output ready);
endinterface

FILE: design/metvt_ctrl.sv
// Controller: sequences sample updates, velocity multiply/divide and result hand-off.
module metvt_ctrl #(
  parameter int ANGLE_BITS    = metvt_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_BITS = metvt_pkg::ROTATION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output metvt_pkg::cmd_t       cmd_o,
  input  metvt_pkg::status_t    sts_i
);

  localparam int MAGW = ANGLE_BITS + ROTATION_BITS + 1;
  localparam int NCH  = (MAGW + metvt_pkg::CHUNK_W - 1) / metvt_pkg::CHUNK_W;
  localparam int CNTW = $clog2(metvt_pkg::DIV_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == metvt_pkg::OP_VELOCITY) begin
            cmd_o.load_velocity = 1'b1;
            cnt_d   = CNTW'(NCH - 1);
            state_d = ST_MUL;
          end else begin
            cmd_o.load_sample = 1'b1;
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_CHK: begin
        cmd_o.div_check = 1'b1;
        if (sts_i.ovf) begin
          state_d = ST_OUT;
        end else begin
          cnt_d   = CNTW'(metvt_pkg::DIV_STEPS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/metvt_dp.sv
// Datapath: tracker state, config registers, serial multiply, restoring divide, result word.
module metvt_dp #(
  parameter int ANGLE_BITS    = metvt_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_BITS = metvt_pkg::ROTATION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [metvt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [metvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [metvt_pkg::BYTE_W-1:0]         hi_byte_i,
  input  logic [metvt_pkg::BYTE_W-1:0]         lo_byte_i,
  input  logic [metvt_pkg::TS_W-1:0]           ts_i,
  input  metvt_pkg::cmd_t                      cmd_i,
  output metvt_pkg::status_t                   sts_o,
  output logic [ANGLE_BITS-1:0]                angle_o,
  output logic [ROTATION_BITS-1:0]             rot_o,
  output logic [ANGLE_BITS+ROTATION_BITS:0]    pos_o,
  output logic [metvt_pkg::VEL_W-1:0]          vel_o,
  output logic                                 vel_valid_o
);

  localparam int A     = ANGLE_BITS;
  localparam int R     = ROTATION_BITS;
  localparam int PW    = A + R;
  localparam int DW    = PW + 1;
  localparam int NCH   = (DW + metvt_pkg::CHUNK_W - 1) / metvt_pkg::CHUNK_W;
  localparam int PADW  = NCH * metvt_pkg::CHUNK_W;
  localparam int NW    = DW + metvt_pkg::VEL_SCALE_W;
  localparam int CW    = metvt_pkg::CHUNK_W;
  localparam int VW    = metvt_pkg::VEL_W;
  localparam int TW    = metvt_pkg::TS_W;
  localparam int PRODW = CW + metvt_pkg::VEL_SCALE_W;
  localparam int CMPW  = (A > metvt_pkg::THR_W) ? A : metvt_pkg::THR_W;

  localparam logic [R-1:0]  RMAX      = {1'b0, {(R-1){1'b1}}};
  localparam logic [R-1:0]  RMIN      = {1'b1, {(R-1){1'b0}}};
  localparam logic [VW-1:0] LIM_POS   = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] LIM_NEG   = {1'b1, {(VW-1){1'b0}}};
  localparam logic [metvt_pkg::FB_W-1:0] FB_ONE = {{(metvt_pkg::FB_W-1){1'b0}}, 1'b1};

  // architectural state
  logic [A-1:0]  prev_angle_q, snap_angle_q;
  logic [TW-1:0] prev_time_q, snap_time_q;
  logic [R-1:0]  rot_q, snap_rot_q;
  logic          primed_q;
  logic [metvt_pkg::THR_W-1:0] thr_q;
  logic [metvt_pkg::FB_W-1:0]  fb_q;

  // velocity working registers
  logic [NW-1:0]   acc_q;
  logic [PADW-1:0] mag_q;
  logic [TW-1:0]   dt_q;
  logic [VW-1:0]   rem_q, lo_q;
  logic            neg_q, ovf_q, op_q;

  // result word
  logic [A-1:0]  out_angle_q;
  logic [R-1:0]  out_rot_q;
  logic [VW-1:0] out_vel_q;
  logic          out_vv_q;

  // sample path
  logic [metvt_pkg::RAW_ANG_W-1:0] ang_raw;
  logic [A-1:0]  ang;
  logic [A:0]    d;
  logic [A-1:0]  ad;
  logic          wrap;
  logic [R-1:0]  rot_next;

  assign ang_raw = {hi_byte_i, lo_byte_i[metvt_pkg::BYTE_W-1:2]};
  assign ang     = A'(ang_raw);
  assign d       = {1'b0, ang} - {1'b0, prev_angle_q};
  assign ad      = d[A] ? A'(-d) : d[A-1:0];
  assign wrap    = CMPW'(ad) > CMPW'(thr_q);

  always_comb begin
    rot_next = rot_q;
    if (wrap) begin
      if (!d[A]) begin
        if (rot_q != RMIN) rot_next = rot_q - 1'b1;
      end else begin
        if (rot_q != RMAX) rot_next = rot_q + 1'b1;
      end
    end
  end

  // velocity load path
  logic [PW-1:0] pos_cur, pos_snap;
  logic [DW-1:0] dpos, dmag;
  logic [TW-1:0] dt_raw, dt_sel;

  assign pos_cur  = {rot_q, prev_angle_q};
  assign pos_snap = {snap_rot_q, snap_angle_q};
  assign dpos     = {pos_cur[PW-1], pos_cur} - {pos_snap[PW-1], pos_snap};
  assign dmag     = dpos[DW-1] ? (~dpos + 1'b1) : dpos;
  assign dt_raw   = prev_time_q - snap_time_q;

  always_comb begin
    if (dt_raw != '0) begin
      dt_sel = dt_raw;
    end else if (fb_q != '0) begin
      dt_sel = TW'(fb_q);
    end else begin
      dt_sel = TW'(FB_ONE);
    end
  end

  // multiply and divide steps
  logic [CW-1:0]    chunk;
  logic [PRODW-1:0] prod;
  logic [NW-1:0]    acc_hi;
  logic [VW+1:0]    trial;
  logic             ge;

  assign chunk  = mag_q[PADW-1 -: CW];
  assign prod   = PRODW'(chunk) * PRODW'(metvt_pkg::VEL_SCALE);
  assign acc_hi = acc_q >> VW;
  assign sts_o.ovf = acc_hi >= NW'(dt_q);
  assign trial  = {1'b0, rem_q, lo_q[VW-1]} - {2'b00, dt_q};
  assign ge     = !trial[VW+1];

  // final saturation
  logic [VW-1:0] limit, mag_sat, vel_fin;

  assign limit   = neg_q ? LIM_NEG : LIM_POS;
  assign mag_sat = (ovf_q || (lo_q > limit)) ? limit : lo_q;
  assign vel_fin = !op_q ? '0 : (neg_q ? (~mag_sat + 1'b1) : mag_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      prev_time_q  <= '0;
      rot_q        <= '0;
      snap_angle_q <= '0;
      snap_rot_q   <= '0;
      snap_time_q  <= '0;
      primed_q     <= 1'b0;
      thr_q        <= metvt_pkg::WRAP_THR_RESET;
      fb_q         <= metvt_pkg::FB_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == metvt_pkg::CFG_WRAP_THRESHOLD) begin
          thr_q <= cfg_data_i[metvt_pkg::THR_W-1:0];
        end else if (cfg_index_i == metvt_pkg::CFG_FALLBACK_US) begin
          fb_q <= cfg_data_i[metvt_pkg::FB_W-1:0];
        end
      end
      if (cmd_i.load_sample) begin
        prev_angle_q <= ang;
        prev_time_q  <= ts_i;
        if (!primed_q) begin
          snap_angle_q <= ang;
          snap_rot_q   <= '0;
          snap_time_q  <= ts_i;
          primed_q     <= 1'b1;
        end else begin
          rot_q <= rot_next;
        end
      end
      if (cmd_i.load_velocity) begin
        snap_angle_q <= prev_angle_q;
        snap_rot_q   <= rot_q;
        snap_time_q  <= prev_time_q;
      end
    end
  end

  // working and result registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      op_q <= metvt_pkg::OP_SAMPLE;
    end
    if (cmd_i.load_velocity) begin
      op_q  <= metvt_pkg::OP_VELOCITY;
      neg_q <= dpos[DW-1];
      mag_q <= PADW'(dmag);
      dt_q  <= dt_sel;
      acc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= {acc_q[NW-CW-1:0], {CW{1'b0}}} + NW'(prod);
      mag_q <= mag_q << CW;
    end
    if (cmd_i.div_check) begin
      ovf_q <= sts_o.ovf;
      rem_q <= acc_hi[VW-1:0];
      lo_q  <= acc_q[VW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? trial[VW-1:0] : {rem_q[VW-2:0], lo_q[VW-1]};
      lo_q  <= {lo_q[VW-2:0], ge};
    end
    if (cmd_i.load_out) begin
      out_angle_q <= prev_angle_q;
      out_rot_q   <= rot_q;
      out_vel_q   <= vel_fin;
      out_vv_q    <= op_q;
    end
  end

  assign angle_o     = out_angle_q;
  assign rot_o       = out_rot_q;
  assign pos_o       = {out_rot_q[R-1], out_rot_q, out_angle_q};
  assign vel_o       = out_vel_q;
  assign vel_valid_o = out_vv_q;

endmodule

FILE: design/multiturn_encoder_velocity_tracker_unit.sv
// Top level: multi-turn angle tracker with velocity readout.
//
// Tracks a 14-bit absolute angle sensor across turns. Each input word is either
// a sample (operation 0: two raw sensor bytes and a microsecond timestamp) or a
// velocity read (operation 1). Every word yields exactly one result word with
// the current angle, the saturating rotation count, the multi-turn position
// (rotations * 2^ANGLE_BITS + angle) and, on a velocity read, the position
// change since the previous read in counts per second, truncated toward zero
// and saturated to 32 bits. The first sample after reset only primes the
// tracker. A sample goes from acceptance straight to the result load. A
// velocity read runs the scale-by-10^6 multiply (NCH 16x20-bit partial
// products, NCH = ceil((ANGLE_BITS+ROTATION_BITS+1)/16)), an overflow
// check and the one-bit-per-cycle restoring divider before the result
// load; a read that saturates skips the divider. The next word can be
// accepted on the edge after the result register loads; a result still
// stalled in the output register holds off that load until it is taken. One
// word is in flight at a time; the next word is taken while the previous
// result still waits in the output register.
// Configuration (wrap threshold, fallback interval) must be written only
// while idle; the block itself does not enforce this.
module multiturn_encoder_velocity_tracker_unit #(
  parameter int ANGLE_BITS    = metvt_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_BITS = metvt_pkg::ROTATION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [metvt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [metvt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  metvt_in_if.sink                           in_i,
  metvt_out_if.source                        out_o
);

  metvt_pkg::cmd_t    cmd;
  metvt_pkg::status_t sts;

  logic [ANGLE_BITS-1:0]              angle;
  logic [ROTATION_BITS-1:0]           rot;
  logic [ANGLE_BITS+ROTATION_BITS:0]  pos;
  logic [metvt_pkg::VEL_W-1:0]        vel;
  logic                               vel_valid;

  // sequencer: handshakes and step commands
  metvt_ctrl #(
    .ANGLE_BITS    (ANGLE_BITS),
    .ROTATION_BITS (ROTATION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.operation),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // state, arithmetic and the result word
  metvt_dp #(
    .ANGLE_BITS    (ANGLE_BITS),
    .ROTATION_BITS (ROTATION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .hi_byte_i   (in_i.angle_high_byte),
    .lo_byte_i   (in_i.angle_low_byte),
    .ts_i        (in_i.timestamp_us),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .angle_o     (angle),
    .rot_o       (rot),
    .pos_o       (pos),
    .vel_o       (vel),
    .vel_valid_o (vel_valid)
  );

  assign out_o.angle_counts          = angle;
  assign out_o.rotation_count        = rot;
  assign out_o.position_counts       = pos;
  assign out_o.velocity_counts_per_s = vel;
  assign out_o.velocity_valid        = vel_valid;

endmodule

FILE: design/metvt_checker.sv
// Checker on the result port of the tracker, bound to the top level.
`include "multiturn_encoder_velocity_tracker_unit_assert.svh"

module metvt_checker #(
  parameter int ANGLE_BITS    = metvt_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_BITS = metvt_pkg::ROTATION_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [ANGLE_BITS-1:0]              angle_i,
  input logic [ROTATION_BITS-1:0]           rot_i,
  input logic [ANGLE_BITS+ROTATION_BITS:0]  pos_i,
  input logic [metvt_pkg::VEL_W-1:0]        vel_i,
  input logic                               vel_valid_i
);

  localparam int A = ANGLE_BITS;
  localparam int R = ROTATION_BITS;

  `METVT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result word dropped while stalled")
  `METVT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(pos_i) && $stable(vel_i) && $stable(vel_valid_i), "result word changed while stalled")
  `METVT_ASSERT_SAME(a_sample_vel_zero, clk_i, rst_ni, out_valid_i && !vel_valid_i, vel_i == '0, "sample result carries nonzero velocity")
  `METVT_ASSERT_SAME(a_pos_consistent, clk_i, rst_ni, out_valid_i, (pos_i[A-1:0] == angle_i) && (pos_i[A+R-1:A] == rot_i) && (pos_i[A+R] == rot_i[R-1]), "position disagrees with rotation and angle")

endmodule

bind multiturn_encoder_velocity_tracker_unit metvt_checker #(
  .ANGLE_BITS    (ANGLE_BITS),
  .ROTATION_BITS (ROTATION_BITS)
) u_metvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .angle_i     (out_o.angle_counts),
  .rot_i       (out_o.rotation_count),
  .pos_i       (out_o.position_counts),
  .vel_i       (out_o.velocity_counts_per_s),
  .vel_valid_i (out_o.velocity_valid)
);
